@@ hdl/euclidean_ball_relation_top_assert.svh @@
// assertion macros for the euclidean ball relation block
`ifndef EUCLIDEAN_BALL_RELATION_TOP_ASSERT_SVH
`define EUCLIDEAN_BALL_RELATION_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ebr assertion failed");

// next-cycle implication, checked out of reset
`define EBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ebr assertion failed");

`endif

@@ hdl/ebr_pkg.sv @@
// types and constants shared by the euclidean ball relation modules
package ebr_pkg;

    parameter int VALUE_W    = 16;
    parameter int RADIUS_W   = 24;
    parameter int DIST_W     = 20;
    parameter int MAG_W      = 16;
    parameter int SQ_W       = 32;
    parameter int SUM_W      = 41;
    parameter int BOTH_W     = RADIUS_W + 1;
    parameter int ROOT_STEPS = 21;
    parameter int CNT_W      = 5;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // largest square of one element difference
    parameter sum_t ELEM_SQ_MAX = sum_t'(64'hFFFE_0001);
    // first trial bit of the floor root
    parameter sum_t ROOT_BIT_INIT = sum_t'(1) << (SUM_W - 1);
    parameter cnt_t LAST_STEP = cnt_t'(ROOT_STEPS - 1);

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_ACCUM  = 3'b001,
        ST_ROOT   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_root;
        logic step_root;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_pending;
        logic out_free;
    } status_t;

endpackage

@@ hdl/ebr_ctrl.sv @@
// controller: accumulate, iterate floor root, hand off result
module ebr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  ebr_pkg::status_t st,
    output ebr_pkg::cmd_t    cmd,
    output logic            s_ready
);

    ebr_pkg::state_t state_reg, state_next;
    ebr_pkg::cnt_t   cnt_reg, cnt_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.load_root = 1'b0;
        cmd.step_root = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ebr_pkg::ST_ACCUM: begin
                if (st.last_pending) begin
                    cmd.load_root = 1'b1;
                    cnt_next      = '0;
                    state_next    = ebr_pkg::ST_ROOT;
                end
            end
            ebr_pkg::ST_ROOT: begin
                cmd.step_root = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ebr_pkg::LAST_STEP) begin
                    state_next = ebr_pkg::ST_FINISH;
                end
            end
            ebr_pkg::ST_FINISH: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ebr_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = ebr_pkg::ST_ACCUM;
            end
        endcase
    end

    // input is taken only while accumulating and no last pair is in flight
    assign s_ready = (state_reg == ebr_pkg::ST_ACCUM) && !st.last_pending;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ebr_pkg::ST_ACCUM;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/ebr_datapath.sv @@
// datapath: squared differences, saturating sum, floor root, result register
module ebr_datapath #(
    parameter int MAX_ELEMENTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ebr_pkg::cmd_t                   cmd,
    output ebr_pkg::status_t                st,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [ebr_pkg::VALUE_W-1:0]  s_value_a,
    input  logic signed [ebr_pkg::VALUE_W-1:0]  s_value_b,
    input  logic                            s_present_a,
    input  logic                            s_present_b,
    input  logic [ebr_pkg::RADIUS_W-1:0]    s_radius_a,
    input  logic [ebr_pkg::RADIUS_W-1:0]    s_radius_b,
    input  logic                            s_last_pair,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ebr_pkg::DIST_W-1:0]      m_center_dist,
    output logic [ebr_pkg::DIST_W-1:0]      m_outer_gap,
    output logic                            m_balls_overlap,
    output logic                            m_a_contains_b,
    output logic                            m_b_contains_a,
    output logic                            m_vectors_equal
);

    localparam ebr_pkg::sum_t SumCap =
        ebr_pkg::sum_t'(MAX_ELEMENTS) * ebr_pkg::ELEM_SQ_MAX;

    logic accept_in;

    // first stage: difference, magnitude, square
    logic signed [ebr_pkg::VALUE_W-1:0] a_val, b_val;
    logic signed [ebr_pkg::VALUE_W:0]   diff;
    logic [ebr_pkg::VALUE_W:0]          diff_neg;
    logic [ebr_pkg::MAG_W-1:0]          mag;
    logic                               mismatch;

    logic                               s1_valid_reg;
    logic [ebr_pkg::SQ_W-1:0]           s1_sq_reg;
    logic                               s1_mismatch_reg;
    logic                               s1_last_reg;
    logic [ebr_pkg::RADIUS_W-1:0]       s1_ra_reg, s1_rb_reg;

    // accumulation state
    ebr_pkg::sum_t                      square_sum_reg;
    logic                               still_equal_reg;
    logic [ebr_pkg::SUM_W:0]            acc_wide;
    ebr_pkg::sum_t                      sum_sat;
    logic                               eq_now;

    // root state
    ebr_pkg::sum_t                      root_work_reg;
    ebr_pkg::sum_t                      result_reg;
    ebr_pkg::sum_t                      bit_reg;
    logic [ebr_pkg::SUM_W:0]            trial;
    logic                               take;
    logic                               eq_hold_reg;
    logic [ebr_pkg::RADIUS_W-1:0]       ra_hold_reg, rb_hold_reg;

    // final compares
    logic [ebr_pkg::DIST_W-1:0]         center_dist;
    logic [ebr_pkg::BOTH_W-1:0]         dist_ext, both, dist_plus_a, dist_plus_b, gap_wide;

    logic                               m_valid_reg;

    assign accept_in = s_valid && s_ready;

    always_comb begin
        a_val    = s_present_a ? s_value_a : '0;
        b_val    = s_present_b ? s_value_b : '0;
        diff     = {a_val[ebr_pkg::VALUE_W-1], a_val} - {b_val[ebr_pkg::VALUE_W-1], b_val};
        diff_neg = -diff;
        mag      = diff[ebr_pkg::VALUE_W] ? diff_neg[ebr_pkg::MAG_W-1:0]
                                          : diff[ebr_pkg::MAG_W-1:0];
        mismatch = (s_present_a != s_present_b)
                || (s_present_a && s_present_b && (s_value_a != s_value_b));
    end

    // saturating accumulate of the registered square
    always_comb begin
        acc_wide = {1'b0, square_sum_reg}
                 + {{(ebr_pkg::SUM_W + 1 - ebr_pkg::SQ_W){1'b0}}, s1_sq_reg};
        sum_sat  = (acc_wide > {1'b0, SumCap}) ? SumCap : acc_wide[ebr_pkg::SUM_W-1:0];
        eq_now   = still_equal_reg && !s1_mismatch_reg;
    end

    // one root iteration
    always_comb begin
        trial = {1'b0, result_reg} + {1'b0, bit_reg};
        take  = {1'b0, root_work_reg} >= trial;
    end

    // clamp the root and form the ball relations
    always_comb begin
        center_dist = (|result_reg[ebr_pkg::SUM_W-1:ebr_pkg::DIST_W]) ? '1
                                                 : result_reg[ebr_pkg::DIST_W-1:0];
        dist_ext    = ebr_pkg::BOTH_W'(center_dist);
        both        = ebr_pkg::BOTH_W'(ra_hold_reg) + ebr_pkg::BOTH_W'(rb_hold_reg);
        dist_plus_a = dist_ext + ebr_pkg::BOTH_W'(ra_hold_reg);
        dist_plus_b = dist_ext + ebr_pkg::BOTH_W'(rb_hold_reg);
        gap_wide    = dist_ext - both;
    end

    assign st.last_pending = s1_valid_reg && s1_last_reg;
    assign st.out_free     = !m_valid_reg || m_ready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            square_sum_reg  <= '0;
            still_equal_reg <= 1'b1;
            root_work_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= accept_in;
            if (cmd.load_root) begin
                square_sum_reg  <= '0;
                still_equal_reg <= 1'b1;
                root_work_reg   <= sum_sat;
            end else if (s1_valid_reg) begin
                square_sum_reg  <= sum_sat;
                still_equal_reg <= eq_now;
            end
            if (cmd.step_root && take) begin
                root_work_reg <= root_work_reg - trial[ebr_pkg::SUM_W-1:0];
            end else if (cmd.load_out) begin
                root_work_reg <= '0;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            s1_sq_reg       <= mag * mag;
            s1_mismatch_reg <= mismatch;
            s1_last_reg     <= s_last_pair;
            s1_ra_reg       <= s_radius_a;
            s1_rb_reg       <= s_radius_b;
        end
        if (cmd.load_root) begin
            result_reg  <= '0;
            bit_reg     <= ebr_pkg::ROOT_BIT_INIT;
            eq_hold_reg <= eq_now;
            ra_hold_reg <= s1_ra_reg;
            rb_hold_reg <= s1_rb_reg;
        end else if (cmd.step_root) begin
            result_reg <= take ? ((result_reg >> 1) + bit_reg) : (result_reg >> 1);
            bit_reg    <= bit_reg >> 2;
        end
        if (cmd.load_out) begin
            m_center_dist   <= center_dist;
            m_outer_gap     <= (dist_ext > both) ? gap_wide[ebr_pkg::DIST_W-1:0] : '0;
            m_balls_overlap <= dist_ext < both;
            m_a_contains_b  <= dist_plus_b < ebr_pkg::BOTH_W'(ra_hold_reg);
            m_b_contains_a  <= dist_plus_a < ebr_pkg::BOTH_W'(rb_hold_reg);
            m_vectors_equal <= eq_hold_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/euclidean_ball_relation_top.sv @@
// top level of the euclidean ball relation block
// element pairs are taken one per cycle while the distance sum is built
// after the last pair: its square is registered, the sum is closed into the
// root register, 21 root iterations follow (one result bit per cycle), and the
// compares are registered once the output is free; no new pair is taken meanwhile
// synchronous active-low reset clears the sum, sets the match flag, idles
module euclidean_ball_relation_top #(
    parameter int MAX_ELEMENTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ebr_pkg::VALUE_W-1:0]  s_value_a,
    input  logic signed [ebr_pkg::VALUE_W-1:0]  s_value_b,
    input  logic                            s_present_a,
    input  logic                            s_present_b,
    input  logic [ebr_pkg::RADIUS_W-1:0]    s_radius_a,
    input  logic [ebr_pkg::RADIUS_W-1:0]    s_radius_b,
    input  logic                            s_last_pair,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ebr_pkg::DIST_W-1:0]      m_center_dist,
    output logic [ebr_pkg::DIST_W-1:0]      m_outer_gap,
    output logic                            m_balls_overlap,
    output logic                            m_a_contains_b,
    output logic                            m_b_contains_a,
    output logic                            m_vectors_equal
);

    ebr_pkg::cmd_t    cmd;
    ebr_pkg::status_t st;

    // sequencer
    ebr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    // arithmetic and result register
    ebr_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value_a       (s_value_a),
        .s_value_b       (s_value_b),
        .s_present_a     (s_present_a),
        .s_present_b     (s_present_b),
        .s_radius_a      (s_radius_a),
        .s_radius_b      (s_radius_b),
        .s_last_pair     (s_last_pair),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_center_dist   (m_center_dist),
        .m_outer_gap     (m_outer_gap),
        .m_balls_overlap (m_balls_overlap),
        .m_a_contains_b  (m_a_contains_b),
        .m_b_contains_a  (m_b_contains_a),
        .m_vectors_equal (m_vectors_equal)
    );

    // checks
`include "euclidean_ball_relation_top_assert.svh"

    `EBR_ASSERT_NOW(a_no_input_in_root, cmd.step_root, !s_ready)
    `EBR_ASSERT_NOW(a_load_out_free, cmd.load_out, st.out_free)
    `EBR_ASSERT_NEXT(a_last_stalls_input, s_valid && s_ready && s_last_pair, !s_ready)
    `EBR_ASSERT_NEXT(a_out_drains, m_valid && m_ready && !cmd.load_out, !m_valid)

endmodule

@@ dv/tb_euclidean_ball_relation_top.sv @@
// testbench for the euclidean ball relation block: streamed vectors, predicted ball relations
`timescale 1ns / 1ps

module tb_euclidean_ball_relation_top;

    localparam int VALUE_W     = ebr_pkg::VALUE_W;
    localparam int RADIUS_W    = ebr_pkg::RADIUS_W;
    localparam int DIST_W      = ebr_pkg::DIST_W;
    localparam int MAX_PAIRS   = 256;
    localparam int ITEMS       = 1600;
    localparam int QUIET_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned SUM_CEILING = 64'(MAX_PAIRS) * 64'd65535 * 64'd65535;
    localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 1;

    // value picking modes for random elements
    typedef enum int {
        VAL_FULL,
        VAL_SMALL,
        VAL_EXTREME
    } value_mode_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value_a;
        logic signed [VALUE_W-1:0] value_b;
        logic                      present_a;
        logic                      present_b;
        logic [RADIUS_W-1:0]       radius_a;
        logic [RADIUS_W-1:0]       radius_b;
        logic                      last_pair;
    } pair_t;

    typedef struct {
        logic [DIST_W-1:0] center_dist;
        logic [DIST_W-1:0] outer_gap;
        logic              balls_overlap;
        logic              a_contains_b;
        logic              b_contains_a;
        logic              vectors_equal;
    } relation_t;

    // directed stimulus row, with an optional hand-written result
    typedef struct {
        pair_t     pair;
        bit        typed;
        relation_t want;
    } row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value_a;
    logic signed [VALUE_W-1:0] s_value_b;
    logic                      s_present_a;
    logic                      s_present_b;
    logic [RADIUS_W-1:0]       s_radius_a;
    logic [RADIUS_W-1:0]       s_radius_b;
    logic                      s_last_pair;
    logic                      m_valid;
    logic                      m_ready;
    logic [DIST_W-1:0]         m_center_dist;
    logic [DIST_W-1:0]         m_outer_gap;
    logic                      m_balls_overlap;
    logic                      m_a_contains_b;
    logic                      m_b_contains_a;
    logic                      m_vectors_equal;

    // predictor state
    longint unsigned square_total;
    bit              match_so_far;

    relation_t expected_relations[$];
    row_t      directed_rows[$];
    int        error_count;
    int        items_sent;
    int        cycle_count;
    bit        sender_calm;
    bit        quiet;
    int        stall_left;

    euclidean_ball_relation_top #(
        .MAX_ELEMENTS(MAX_PAIRS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_a      (s_value_a),
        .s_value_b      (s_value_b),
        .s_present_a    (s_present_a),
        .s_present_b    (s_present_b),
        .s_radius_a     (s_radius_a),
        .s_radius_b     (s_radius_b),
        .s_last_pair    (s_last_pair),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_center_dist  (m_center_dist),
        .m_outer_gap    (m_outer_gap),
        .m_balls_overlap(m_balls_overlap),
        .m_a_contains_b (m_a_contains_b),
        .m_b_contains_a (m_b_contains_a),
        .m_vectors_equal(m_vectors_equal)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_euclidean_ball_relation_top: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // largest r with r*r <= x, by bisection
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 21;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // advance the distance sum by one pair; returns 1 when a relation comes out
    function automatic bit predict_relation(input pair_t p, output relation_t r);
        int              a;
        int              b;
        int              d;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned ra;
        longint unsigned rb;
        longint unsigned both;
        a = p.present_a ? int'(p.value_a) : 0;
        b = p.present_b ? int'(p.value_b) : 0;
        d = (a > b) ? a - b : b - a;
        sq = longint'(d) * longint'(d);
        r = '{default: '0};

        if (p.present_a != p.present_b || (p.present_a && a != b)) match_so_far = 1'b0;

        // sum saturates at what the largest vector can reach
        if (square_total >= SUM_CEILING || SUM_CEILING - square_total < sq)
            square_total = SUM_CEILING;
        else
            square_total += sq;

        if (!p.last_pair) return 1'b0;

        root = floor_sqrt(square_total);
        if (root > DIST_MAX) root = DIST_MAX;
        ra = p.radius_a;
        rb = p.radius_b;
        both = ra + rb;
        r.center_dist   = DIST_W'(root);
        r.outer_gap     = (root > both) ? DIST_W'(root - both) : '0;
        r.balls_overlap = root < both;
        r.a_contains_b  = root + rb < ra;
        r.b_contains_a  = root + ra < rb;
        r.vectors_equal = match_so_far;

        square_total = 0;
        match_so_far = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value(input value_mode_t mode);
        case (mode)
            VAL_SMALL: return VALUE_W'($urandom_range(0, 2047)) - 16'd1024;
            VAL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic add_row(input logic [15:0] va, input logic [15:0] vb, input bit pa,
                           input bit pb, input logic [23:0] ra, input logic [23:0] rb,
                           input bit last, input bit typed, input logic [19:0] want_dist,
                           input logic [19:0] gap, input bit ov, input bit acb,
                           input bit bca, input bit eq);
        row_t row;
        row.pair  = '{va, vb, pa, pb, ra, rb, last};
        row.typed = typed;
        row.want  = '{want_dist, gap, ov, acb, bca, eq};
        directed_rows.push_back(row);
    endtask

    // one transaction on the input channel, with an optional gap in front
    task automatic drive_pair(input pair_t p, input bit typed, input relation_t want);
        relation_t r;
        int        n;
        quiet = (items_sent >= ITEMS - QUIET_ITEMS);
        @(negedge aclk);
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_value_a   <= p.value_a;
        s_value_b   <= p.value_b;
        s_present_a <= p.present_a;
        s_present_b <= p.present_b;
        s_radius_a  <= p.radius_a;
        s_radius_b  <= p.radius_b;
        s_last_pair <= p.last_pair;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (predict_relation(p, r)) expected_relations.push_back(typed ? want : r);
    endtask

    // result channel: random stall bursts, none near the end
    initial begin
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (aresetn && !quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            if (!aresetn || stall_left > 0) begin
                m_ready <= 1'b0;
                if (stall_left > 0) stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        relation_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_relations.size() == 0) begin
                report_mismatch("result with no expectation pending");
            end else begin
                want = expected_relations.pop_front();
                if (m_center_dist !== want.center_dist)
                    report_mismatch($sformatf("center_dist got %0h want %0h",
                                              m_center_dist, want.center_dist));
                if (m_outer_gap !== want.outer_gap)
                    report_mismatch($sformatf("outer_gap got %0h want %0h",
                                              m_outer_gap, want.outer_gap));
                if (m_balls_overlap !== want.balls_overlap)
                    report_mismatch($sformatf("balls_overlap got %b want %b",
                                              m_balls_overlap, want.balls_overlap));
                if (m_a_contains_b !== want.a_contains_b)
                    report_mismatch($sformatf("a_contains_b got %b want %b",
                                              m_a_contains_b, want.a_contains_b));
                if (m_b_contains_a !== want.b_contains_a)
                    report_mismatch($sformatf("b_contains_a got %b want %b",
                                              m_b_contains_a, want.b_contains_a));
                if (m_vectors_equal !== want.vectors_equal)
                    report_mismatch($sformatf("vectors_equal got %b want %b",
                                              m_vectors_equal, want.vectors_equal));
            end
        end
    end

    // main stimulus
    initial begin
        pair_t       p;
        relation_t   none;
        int          len;
        int          len_a;
        int          len_b;
        int          kind;
        int          vec_count;
        value_mode_t mode;
        logic [15:0] va;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_value_a   = '0;
        s_value_b   = '0;
        s_present_a = 1'b0;
        s_present_b = 1'b0;
        s_radius_a  = '0;
        s_radius_b  = '0;
        s_last_pair = 1'b0;
        error_count = 0;
        items_sent  = 0;
        sender_calm = 1'b0;
        quiet       = 1'b0;
        square_total = 0;
        match_so_far = 1'b1;
        none = '{default: '0};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // both absent, zero radii: nothing differs
        add_row(16'h7FFF, 16'h8000, 0, 0, 24'h0, 24'h0, 1, 1, 20'h0, 20'h0, 0, 0, 0, 1);
        // widest single difference
        add_row(16'h7FFF, 16'h8000, 1, 1, 24'h0, 24'h0, 1, 1,
                20'h0FFFF, 20'h0FFFF, 0, 0, 0, 0);
        // equal extremes, largest radius a
        add_row(16'h8000, 16'h8000, 1, 1, 24'hFFFFFF, 24'h0, 1, 1,
                20'h0, 20'h0, 1, 1, 0, 1);
        // presence differs at zero value, largest radius b
        add_row(16'h0000, 16'h1234, 1, 0, 24'h0, 24'hFFFFFF, 1, 1,
                20'h0, 20'h0, 1, 0, 1, 0);
        // 0x100 apart, gap left over
        add_row(16'h0100, 16'h0000, 1, 1, 24'h80, 24'h40, 1, 1,
                20'h100, 20'h40, 0, 0, 0, 0);
        // both radii at maximum
        add_row(16'h7FFF, 16'h8000, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 1, 1,
                20'h0FFFF, 20'h0, 1, 0, 0, 0);
        // equal vectors ending in a both-absent pair
        add_row(16'h0123, 16'h0123, 1, 1, 24'h55AA55, 24'hAA55AA, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'hFFFB, 16'hFFFB, 1, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'h4321, 16'h1111, 0, 0, 24'h000123, 24'h000456, 1, 0, 0, 0, 0, 0, 0, 0);
        // first vector longer
        add_row(16'd100, 16'd50, 1, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'd200, -16'sd200, 1, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'd300, 16'hFFFF, 1, 0, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'hFFFF, 16'h7FFF, 1, 0, 24'h000400, 24'h000100, 1, 0, 0, 0, 0, 0, 0, 0);
        // second vector longer
        add_row(16'h7FFF, 16'd7, 0, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'h8000, 16'h8000, 0, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'h0001, 16'h0002, 0, 1, 24'h010000, 24'h000001, 1, 0, 0, 0, 0, 0, 0, 0);
        // distance lands exactly on the sum of radii
        add_row(16'h0300, 16'h0000, 1, 1, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(16'h0400, 16'h0000, 1, 1, 24'h000280, 24'h000280, 1, 0, 0, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
            drive_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);

        // random vectors
        vec_count = 0;
        while (items_sent < ITEMS) begin
            kind = $urandom_range(0, 99);
            sender_calm = ($urandom_range(0, 3) == 0);
            if (vec_count == 3 || kind < 2) begin
                // long run of widest differences, drives the sum into saturation
                len = $urandom_range(MAX_PAIRS, MAX_PAIRS + 44);
                for (int i = 0; i < len; i++) begin
                    p.value_a   = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    p.value_b   = ~p.value_a;
                    p.present_a = 1'b1;
                    p.present_b = 1'b1;
                    p.radius_a  = RADIUS_W'($urandom());
                    p.radius_b  = RADIUS_W'($urandom());
                    p.last_pair = (i == len - 1);
                    if (p.last_pair && $urandom_range(0, 1)) begin
                        p.radius_a = 24'($urandom_range(0, 1 << 20));
                        p.radius_b = 24'($urandom_range(0, 1 << 20));
                    end
                    drive_pair(p, 1'b0, none);
                end
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                len_a = $urandom_range(0, 2) == 0 ? $urandom_range(0, len) : len;
                len_b = $urandom_range(0, 2) == 0 ? $urandom_range(0, len) : len;
                if (kind < 35) len_b = len_a;
                mode = value_mode_t'($urandom_range(0, 2));
                for (int i = 0; i < len; i++) begin
                    p.present_a = (i < len_a);
                    p.present_b = (i < len_b);
                    if ($urandom_range(0, 19) == 0) p.present_a = ~p.present_a;
                    if ($urandom_range(0, 19) == 0) p.present_b = ~p.present_b;
                    va = rand_value(mode);
                    p.value_a = va;
                    // matching vectors copy a into b, now and then with a flipped bit
                    if (kind < 35) begin
                        p.value_b = va;
                        if ($urandom_range(0, 15) == 0)
                            p.value_b[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
                    end else begin
                        p.value_b = rand_value(mode);
                    end
                    p.radius_a  = RADIUS_W'($urandom());
                    p.radius_b  = RADIUS_W'($urandom());
                    p.last_pair = (i == len - 1);
                    if (p.last_pair) begin
                        case ($urandom_range(0, 3))
                            0: ;
                            1: begin
                                p.radius_a = 24'($urandom_range(0, 1 << 12));
                                p.radius_b = 24'($urandom_range(0, 1 << 12));
                            end
                            2: begin
                                p.radius_a = 24'($urandom_range(0, 1 << 18));
                                p.radius_b = 24'($urandom_range(0, 1 << 18));
                            end
                            default: begin
                                p.radius_a = $urandom_range(0, 1) ? 24'h0 : 24'($urandom());
                                p.radius_b = 24'h0;
                            end
                        endcase
                    end
                    drive_pair(p, 1'b0, none);
                end
            end
            vec_count++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (expected_relations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb_euclidean_ball_relation_top: done, clean");
        end else begin
            $display("tb_euclidean_ball_relation_top: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ebr_pkg.sv
hdl/ebr_ctrl.sv
hdl/ebr_datapath.sv
hdl/euclidean_ball_relation_top.sv
dv/tb_euclidean_ball_relation_top.sv
